// ===== src/fucs_pkg.sv =====
// fucs_pkg: shared types, constants and the control store of the
// first-unique-character stream block. No dependencies.
`default_nettype none

package fucs_pkg;

  // Alphabet and field widths
  localparam int ALPHABET_SIZE = 128;
  localparam int CHAR_W        = 7;
  localparam int IDX_W         = $clog2(ALPHABET_SIZE);
  localparam int PTR_W         = $clog2(ALPHABET_SIZE + 1);
  localparam int CNT_W         = 2;

  localparam logic [CHAR_W-1:0] NONE_CHAR = CHAR_W'(35);
  localparam logic [CNT_W-1:0]  CNT_ONCE  = CNT_W'(1);
  localparam logic [CNT_W-1:0]  CNT_MULTI = CNT_W'(2);

  // Sequencer steps
  typedef enum logic [2:0] {
    S_IDLE,
    S_UPD,
    S_HREAD,
    S_CREAD,
    S_CHECK,
    S_EMIT
  } fucs_step_t;

  // Branch conditions of a control word
  typedef enum logic [2:0] {
    COND_ALWAYS,
    COND_IN,
    COND_EMPTY,
    COND_ONCE,
    COND_OUT
  } fucs_cond_t;

  // Actions of a control word
  typedef struct packed {
    logic take;   // offer input ready, read count at the new character
    logic upd;    // bump count, push first sighting
    logic probe;  // test queue for empty, read queue head
    logic cread;  // read count of the head character
    logic check;  // test head count, advance or settle result
    logic emit;   // move result into the output register
  } fucs_act_t;

  // One control word: act, then branch to jump when cond holds, else next
  typedef struct packed {
    fucs_act_t  act;
    fucs_cond_t cond;
    fucs_step_t jump;
    fucs_step_t next;
  } fucs_uop_t;

  // Strobes from sequencer to datapath
  typedef struct packed {
    logic in_ready;
    logic cnt_rd_char;
    logic cnt_rd_q;
    logic upd;
    logic q_rd;
    logic set_none;
    logic set_char;
    logic adv_head;
    logic emit;
  } fucs_ctrl_t;

  // Status from datapath to sequencer
  typedef struct packed {
    logic in_valid;
    logic empty;
    logic once;
    logic out_free;
  } fucs_stat_t;

  // Control store
  function automatic fucs_uop_t fucs_ucode(input fucs_step_t step);
    fucs_uop_t u;
    u.act  = '0;
    u.cond = COND_ALWAYS;
    u.jump = S_IDLE;
    u.next = S_IDLE;
    case (step)
      S_IDLE: begin
        u.act.take = 1'b1;
        u.cond     = COND_IN;
        u.jump     = S_UPD;
        u.next     = S_IDLE;
      end
      S_UPD: begin
        u.act.upd = 1'b1;
        u.jump    = S_HREAD;
        u.next    = S_HREAD;
      end
      S_HREAD: begin
        u.act.probe = 1'b1;
        u.cond      = COND_EMPTY;
        u.jump      = S_EMIT;
        u.next      = S_CREAD;
      end
      S_CREAD: begin
        u.act.cread = 1'b1;
        u.jump      = S_CHECK;
        u.next      = S_CHECK;
      end
      S_CHECK: begin
        u.act.check = 1'b1;
        u.cond      = COND_ONCE;
        u.jump      = S_EMIT;
        u.next      = S_HREAD;
      end
      S_EMIT: begin
        u.act.emit = 1'b1;
        u.cond     = COND_OUT;
        u.jump     = S_IDLE;
        u.next     = S_EMIT;
      end
      default: begin
        u.jump = S_IDLE;
        u.next = S_IDLE;
      end
    endcase
    return u;
  endfunction

endpackage

`default_nettype wire

// ===== src/fucs_ifs.sv =====
// fucs_in_if / fucs_out_if: valid/ready channels for characters and results.
// Depends on fucs_pkg for the field widths.
`default_nettype none

interface fucs_in_if import fucs_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [CHAR_W-1:0] char_in;

  modport source (output valid, output char_in, input ready);
  modport sink   (input valid, input char_in, output ready);
endinterface

interface fucs_out_if import fucs_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [CHAR_W-1:0] first_once_char;
  logic              none_found;

  modport source (output valid, output first_once_char, output none_found, input ready);
  modport sink   (input valid, input first_once_char, input none_found, output ready);
endinterface

`default_nettype wire

// ===== src/fucs_seq.sv =====
// fucs_seq: step counter and control-store lookup with conditional branches.
// Depends on fucs_pkg (control store, control and status structs).
`default_nettype none

module fucs_seq import fucs_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire fucs_stat_t stat,
  output fucs_ctrl_t      ctrl
);

  fucs_step_t step;
  fucs_step_t step_next;
  fucs_uop_t  uop;
  logic       taken;

  // Hold the step counter
  always_ff @(posedge clk) begin
    if (rst) begin
      step <= S_IDLE;
    end else begin
      step <= step_next;
    end
  end

  // Decode the control word, resolve the branch, drive strobes
  always_comb begin
    uop = fucs_ucode(step);
    case (uop.cond)
      COND_ALWAYS: taken = 1'b1;
      COND_IN:     taken = stat.in_valid;
      COND_EMPTY:  taken = stat.empty;
      COND_ONCE:   taken = stat.once;
      COND_OUT:    taken = stat.out_free;
      default:     taken = 1'b1;
    endcase
    step_next = taken ? uop.jump : uop.next;

    ctrl.in_ready    = uop.act.take;
    ctrl.cnt_rd_char = uop.act.take;
    ctrl.cnt_rd_q    = uop.act.cread;
    ctrl.upd         = uop.act.upd;
    ctrl.q_rd        = uop.act.probe & ~stat.empty;
    ctrl.set_none    = uop.act.probe & stat.empty;
    ctrl.set_char    = uop.act.check & stat.once;
    ctrl.adv_head    = uop.act.check & ~stat.once;
    ctrl.emit        = uop.act.emit & stat.out_free;
  end

endmodule

`default_nettype wire

// ===== src/fucs_dp.sv =====
// fucs_dp: count store with seen flags, first-seen queue, head/tail pointers,
// result and output registers. Depends on fucs_pkg and fucs_ifs.
`default_nettype none

module fucs_dp import fucs_pkg::*; (
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire fucs_ctrl_t ctrl,
  output fucs_stat_t stat,
  fucs_in_if.sink    chars,
  fucs_out_if.source result
);

  // Count store: memory plus a seen flag per character cleared by reset
  logic [CNT_W-1:0]         cnt_mem [ALPHABET_SIZE];
  logic [ALPHABET_SIZE-1:0] seen;
  logic [CNT_W-1:0]         cnt_rd;
  logic                     seen_rd;

  // First-seen queue, contents undefined until written
  logic [CHAR_W-1:0] q_mem [ALPHABET_SIZE];
  logic [CHAR_W-1:0] q_rd;
  logic [PTR_W-1:0]  head;
  logic [PTR_W-1:0]  tail;

  logic [CHAR_W-1:0] cur_char;
  logic [CHAR_W-1:0] res_char;
  logic              res_none;
  logic              out_valid;
  logic [CHAR_W-1:0] out_char;
  logic              out_none;

  logic              accept;
  logic              in_range;
  logic [IDX_W-1:0]  cur_idx;
  logic [IDX_W-1:0]  cnt_addr;
  logic [CNT_W-1:0]  cnt_eff;
  logic [CNT_W-1:0]  cnt_new;
  logic              push;

  assign accept   = ctrl.in_ready & chars.valid;
  assign in_range = 32'(cur_char) < 32'(ALPHABET_SIZE);
  assign cur_idx  = IDX_W'(cur_char);
  assign cnt_addr = ctrl.cnt_rd_q ? IDX_W'(q_rd) : IDX_W'(chars.char_in);
  assign cnt_eff  = seen_rd ? cnt_rd : '0;
  assign cnt_new  = (cnt_eff == CNT_MULTI) ? CNT_MULTI : cnt_eff + CNT_W'(1);
  assign push     = ctrl.upd & in_range & (cnt_eff == '0) &
                    (tail < PTR_W'(ALPHABET_SIZE));

  // Status to the sequencer
  assign stat.in_valid = chars.valid;
  assign stat.empty    = (head == tail);
  assign stat.once     = seen_rd & (cnt_rd == CNT_ONCE);
  assign stat.out_free = ~out_valid | result.ready;

  assign chars.ready            = ctrl.in_ready;
  assign result.valid           = out_valid;
  assign result.first_once_char = out_char;
  assign result.none_found      = out_none;

  // Control state: seen flags, pointers, output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      seen      <= '0;
      head      <= '0;
      tail      <= '0;
      out_valid <= 1'b0;
    end else begin
      if (ctrl.upd && in_range) begin
        seen[cur_idx] <= 1'b1;
      end
      if (push) begin
        tail <= tail + PTR_W'(1);
      end
      if (ctrl.adv_head) begin
        head <= head + PTR_W'(1);
      end
      if (ctrl.emit) begin
        out_valid <= 1'b1;
      end else if (result.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Latch the accepted character
  always_ff @(posedge clk) begin
    if (accept) begin
      cur_char <= chars.char_in;
    end
  end

  // Count store port: registered read, write on update
  always_ff @(posedge clk) begin
    if (ctrl.cnt_rd_char || ctrl.cnt_rd_q) begin
      cnt_rd  <= cnt_mem[cnt_addr];
      seen_rd <= seen[cnt_addr];
    end
    if (ctrl.upd && in_range) begin
      cnt_mem[cur_idx] <= cnt_new;
    end
  end

  // Queue port: push at tail, registered read at head
  always_ff @(posedge clk) begin
    if (push) begin
      q_mem[tail[IDX_W-1:0]] <= cur_char;
    end
    if (ctrl.q_rd) begin
      q_rd <= q_mem[head[IDX_W-1:0]];
    end
  end

  // Settle the result, then load the output register
  always_ff @(posedge clk) begin
    if (ctrl.set_none) begin
      res_char <= NONE_CHAR;
      res_none <= 1'b1;
    end else if (ctrl.set_char) begin
      res_char <= q_rd;
      res_none <= 1'b0;
    end
    if (ctrl.emit) begin
      out_char <= res_char;
      out_none <= res_none;
    end
  end

  a_head_le_tail: assert property (@(posedge clk) disable iff (rst)
    head <= tail) else $error("queue head passed tail");

  a_tail_bound: assert property (@(posedge clk) disable iff (rst)
    tail <= PTR_W'(ALPHABET_SIZE)) else $error("queue tail beyond alphabet size");

  a_adv_nonempty: assert property (@(posedge clk) disable iff (rst)
    ctrl.adv_head |-> (head != tail)) else $error("head advanced on empty queue");

  a_tail_step: assert property (@(posedge clk) disable iff (rst)
    ctrl.upd |=> (tail == $past(tail)) || (tail == $past(tail) + PTR_W'(1)))
    else $error("tail moved by more than one");

  a_none_char: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_none) |-> (out_char == NONE_CHAR))
    else $error("none result without marker character");

endmodule

`default_nettype wire

// ===== src/first_unique_char_stream.sv =====
// first_unique_char_stream: earliest character seen exactly once in a stream.
// Depends on fucs_pkg, fucs_ifs, fucs_seq and fucs_dp.
//
//   channel  modport  payload                        role
//   chars    sink     char_in[6:0]                   one character per transfer
//   result   source   first_once_char[6:0], none_found  one answer per character
//
// One character at a time: after a transfer on chars, the update, head read,
// count read and check steps run before the result enters the output register
// (emit follows head read when the queue is found empty), and head read, count
// read and check repeat for each stale queue entry the head skips; the single
// count-store read port sets this. Each character skips the head at most once.
// Reset clears per-character seen flags at once: no clearing pass.
// A waiting result stalls only the emit step; the next character is taken
// while it sits in the output register.
`default_nettype none

module first_unique_char_stream import fucs_pkg::*; (
  input wire logic   clk,
  input wire logic   rst,
  fucs_in_if.sink    chars,
  fucs_out_if.source result
);

  fucs_ctrl_t ctrl;
  fucs_stat_t stat;

  // Sequencer
  fucs_seq u_seq (
    .clk  (clk),
    .rst  (rst),
    .stat (stat),
    .ctrl (ctrl)
  );

  // Datapath
  fucs_dp u_dp (
    .clk    (clk),
    .rst    (rst),
    .ctrl   (ctrl),
    .stat   (stat),
    .chars  (chars),
    .result (result)
  );

endmodule

`default_nettype wire
